// File: rtl/prpzs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpzs_pkg
// shared types, widths and constants of the point plotter
// ----------------------------------------------------------------------------
package prpzs_pkg;

  localparam int COORD_W = 23;   // rotated coordinate, signed q14
  localparam int MA_W    = 24;   // multiplier operand a
  localparam int MB_W    = 19;   // multiplier operand b
  localparam int PROD_W  = 43;
  localparam int ACC_W   = 44;
  localparam int NUM_W   = 32;   // divider numerator / quotient
  localparam int DEN_W   = 24;   // divider denominator
  localparam int CELL_W  = 13;   // cell index port width
  localparam int GLYPH_W = 7;

  localparam logic [3:0] BLANK_CODE = 4'd12;
  localparam logic [6:0] GLYPH_SPACE = 7'd32;
  localparam logic signed [MB_W-1:0] SHADE_K = 19'sd254875;
  localparam int W_OFFSET = 81920;  // 5.0 in q14

  // item kinds as classified by the front end
  localparam logic [1:0] KIND_PLOT = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_SKIP = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_COS_X = 3'd0;
  localparam logic [2:0] REG_SIN_X = 3'd1;
  localparam logic [2:0] REG_COS_Y = 3'd2;
  localparam logic [2:0] REG_SIN_Y = 3'd3;
  localparam logic [2:0] REG_COS_Z = 3'd4;
  localparam logic [2:0] REG_SIN_Z = 3'd5;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] sx;
    logic signed [15:0] cy;
    logic signed [15:0] sy;
    logic signed [15:0] cz;
    logic signed [15:0] sz;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [14:0] ax;
    logic [12:0]        addr;
  } item_t;

  typedef struct packed {
    logic              written;
    logic [CELL_W-1:0] cell_no;
    logic [6:0]        glyph;
  } result_t;

  function automatic logic [6:0] glyph_of(input logic [3:0] code);
    logic [6:0] g;
    unique case (code)
      4'd0:    g = 7'd46;   // .
      4'd1:    g = 7'd44;   // ,
      4'd2:    g = 7'd45;   // -
      4'd3:    g = 7'd126;  // ~
      4'd4:    g = 7'd58;   // :
      4'd5:    g = 7'd59;   // ;
      4'd6:    g = 7'd61;   // =
      4'd7:    g = 7'd33;   // !
      4'd8:    g = 7'd42;   // *
      4'd9:    g = 7'd35;   // #
      4'd10:   g = 7'd36;   // $
      4'd11:   g = 7'd64;   // @
      default: g = GLYPH_SPACE;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/point_rotate_project_zbuffer_shade_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_project_zbuffer_shade_top
// rotates cylinder surface points, projects them, depth tests and shades them
// into a character cell buffer; read requests return and clear one cell
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         push / full            opcode unit_x unit_y axial_pos cell_addr
// result    out        pop / empty            written cell_out glyph
// config    in         cfg_write              cfg_index cfg_data
//
// a depth-tested plot makes two rotation passes on the shared multiplier in the
// back end, one before and one after three divisions on the serial divider
// (start, quotient steps, done), then shading and a read-modify-write of the
// cell memory; a point that falls off screen or behind the camera leaves early.
// after reset the cell memory is swept, one cell per cycle, over all
// SCREEN_COLS*SCREEN_ROWS cells with full held high.
// two-entry queues on each side let producer and consumer stall freely.
// ----------------------------------------------------------------------------
module point_rotate_project_zbuffer_shade_top #(
  parameter int SCREEN_COLS = 160,
  parameter int SCREEN_ROWS = 44
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic signed [15:0]  unit_x,
  input  logic signed [15:0]  unit_y,
  input  logic signed [14:0]  axial_pos,
  input  logic [12:0]         cell_addr,
  output logic                empty,
  input  logic                pop,
  output logic                written,
  output logic [12:0]         cell_out,
  output logic [6:0]          glyph,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import prpzs_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid, item_ready, hold;
  result_t res, head;
  logic    res_valid, res_ready;

  // rotation registers, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cx: 16'sd16384, sx: 16'sd0, cy: 16'sd16384, sy: 16'sd0,
               cz: 16'sd16384, sz: 16'sd0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COS_X: cfg.cx <= cfg_data;
        REG_SIN_X: cfg.sx <= cfg_data;
        REG_COS_Y: cfg.cy <= cfg_data;
        REG_SIN_Y: cfg.sy <= cfg_data;
        REG_COS_Z: cfg.cz <= cfg_data;
        REG_SIN_Z: cfg.sz <= cfg_data;
        default:   cfg <= cfg;  // unknown index is ignored
      endcase
    end
  end

  // front end: classify and queue requests
  prpzs_front #(
    .CELLS (SCREEN_COLS * SCREEN_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .axial_pos  (axial_pos),
    .cell_addr  (cell_addr),
    .hold       (hold),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  // back end: transform, divide, shade, depth buffer
  prpzs_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .hold       (hold),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  // result queue
  prpzs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .head      (head),
    .empty     (empty),
    .pop       (pop)
  );

  assign written  = head.written;
  assign cell_out = head.cell_no;
  assign glyph    = head.glyph;

endmodule

// File: rtl/prpzs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpzs_front
// accepts requests, classifies them and buffers them for the back end
// ----------------------------------------------------------------------------
module prpzs_front #(
  parameter int CELLS = 7040
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic signed [15:0]    unit_x,
  input  logic signed [15:0]    unit_y,
  input  logic signed [14:0]    axial_pos,
  input  logic [12:0]           cell_addr,
  input  logic                  hold,
  output prpzs_pkg::item_t      item,
  output logic                  item_valid,
  input  logic                  item_ready
);
  import prpzs_pkg::*;

  item_t      ent [2];
  logic       wp, rp;
  logic [1:0] cnt;
  item_t      incoming;
  logic       do_push, do_pop;

  always_comb begin
    incoming.ux   = unit_x;
    incoming.uy   = unit_y;
    incoming.ax   = axial_pos;
    incoming.addr = cell_addr;
    if (!opcode) begin
      incoming.kind = KIND_PLOT;
    end else if (32'(cell_addr) < 32'(CELLS)) begin
      incoming.kind = KIND_READ;
    end else begin
      incoming.kind = KIND_SKIP;
    end
  end

  assign full       = (cnt == 2'd2) || hold;
  assign do_push    = push && !full;
  assign item_valid = (cnt != 2'd0);
  assign do_pop     = item_valid && item_ready;
  assign item       = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wp] <= incoming;
    end
  end

endmodule

// File: rtl/prpzs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpzs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module prpzs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [prpzs_pkg::NUM_W-1:0]   num,
  input  logic [prpzs_pkg::DEN_W-1:0]   den,
  output logic                          done,
  output logic [prpzs_pkg::NUM_W-1:0]   quo
);
  import prpzs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, q[NUM_W-1]};
  assign fits  = trial >= {1'b0, dreg};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(NUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      q <= {q[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, dreg});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

endmodule

// File: rtl/prpzs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpzs_back
// sequenced transform, projection, shading and depth buffer update; also cell reads
// ----------------------------------------------------------------------------
module prpzs_back #(
  parameter int SCREEN_COLS = 160,
  parameter int SCREEN_ROWS = 44
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prpzs_pkg::cfg_t       cfg,
  input  prpzs_pkg::item_t      item,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  hold,
  output prpzs_pkg::result_t    res,
  output logic                  res_valid,
  input  logic                  res_ready
);
  import prpzs_pkg::*;

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int XP_W  = $clog2(SCREEN_COLS);
  localparam int YP_W  = $clog2(SCREEN_ROWS);
  localparam logic signed [NUM_W:0] K_COLS = (NUM_W+1)'(SCREEN_COLS);
  localparam logic signed [NUM_W:0] K_ROWS = (NUM_W+1)'(SCREEN_ROWS + 4);
  localparam logic signed [NUM_W:0] K_60   = (NUM_W+1)'(60);
  localparam logic signed [NUM_W:0] K_30   = (NUM_W+1)'(30);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_PROJ  = 4'd3;
  localparam logic [3:0] S_DX    = 4'd4;
  localparam logic [3:0] S_DXW   = 4'd5;
  localparam logic [3:0] S_DY    = 4'd6;
  localparam logic [3:0] S_DYW   = 4'd7;
  localparam logic [3:0] S_DD    = 4'd8;
  localparam logic [3:0] S_DDW   = 4'd9;
  localparam logic [3:0] S_SHM   = 4'd10;
  localparam logic [3:0] S_SHA   = 4'd11;
  localparam logic [3:0] S_CMP   = 4'd12;
  localparam logic [3:0] S_RD    = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0]               st;
  logic [AW-1:0]            clr;
  logic [1:0]               rot;
  logic [2:0]               stp;
  logic                     pass;
  logic signed [COORD_W-1:0] vx, vy, vz, pn;
  logic signed [15:0]       nux, nuy;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [DEN_W-1:0]         wreg;
  logic signed [NUM_W:0]    xnum, ynum;
  logic [XP_W-1:0]          xp;
  logic [YP_W-1:0]          yp;
  logic [15:0]              dq;
  logic [AW-1:0]            cell_idx;
  logic [3:0]               idx;

  // rotation operand selection
  logic signed [COORD_W-1:0] p_sel, q_sel, qn;
  logic signed [15:0]        c_sel, s_sel;
  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [PROD_W-1:0]  mul;
  logic signed [COORD_W:0]   wsum;
  logic signed [ACC_W-1:0]   shv;

  // divider
  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [DEN_W-1:0]     div_den;

  // depth and shade memory, {shade, depth}
  logic [19:0]          mem [CELLS];
  logic [19:0]          rd_data, wd;
  logic [AW-1:0]        ra, wa;
  logic                 we;

  function automatic logic signed [COORD_W-1:0] rq14(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(8192);
    return t[COORD_W+13:14];
  endfunction

  always_comb begin
    unique case (rot)
      2'd0: begin p_sel = vy; q_sel = vz; c_sel = cfg.cx; s_sel = cfg.sx; end
      2'd1: begin p_sel = vz; q_sel = vx; c_sel = cfg.cy; s_sel = cfg.sy; end
      default: begin p_sel = vx; q_sel = vy; c_sel = cfg.cz; s_sel = cfg.sz; end
    endcase
    if (st == S_SHM) begin
      ma = MA_W'(vy) - MA_W'(vz);
      mb = SHADE_K;
    end else begin
      unique case (stp)
        3'd1, 3'd2: ma = MA_W'(q_sel);
        default:    ma = MA_W'(p_sel);
      endcase
      unique case (stp)
        3'd1, 3'd3: mb = MB_W'(s_sel);
        default:    mb = MB_W'(c_sel);
      endcase
    end
  end

  assign mul  = PROD_W'(ma) * PROD_W'(mb);
  assign qn   = rq14(acc + ACC_W'(prod));
  assign wsum = (COORD_W+1)'(vz) + (COORD_W+1)'(W_OFFSET);
  assign shv  = ACC_W'(prod) + (ACC_W'(11) <<< 29);

  assign item_ready = (st == S_IDLE);
  assign hold       = (st == S_CLEAR);
  assign res_valid  = (st == S_EMIT);

  always_comb begin
    div_start = 1'b0;
    div_num   = xnum[NUM_W-1:0];
    div_den   = DEN_W'({wreg, 1'b0});
    unique case (st)
      S_DX: div_start = (xnum > 0);
      S_DY: begin
        div_start = (ynum > 0);
        div_num   = ynum[NUM_W-1:0];
      end
      S_DD: begin
        div_start = 1'b1;
        div_num   = NUM_W'(32'h4000_0000);
        div_den   = wreg;
      end
      default: div_start = 1'b0;
    endcase
  end

  prpzs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    we = 1'b0;
    wa = cell_idx;
    wd = {BLANK_CODE, 16'd0};
    ra = cell_idx;
    unique case (st)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr;
      end
      S_IDLE: ra = item.addr[AW-1:0];
      S_RD:   we = 1'b1;
      S_CMP: begin
        we = (dq > rd_data[15:0]);
        wd = {idx, dq};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_CLEAR;
      clr <= '0;
    end else begin
      unique case (st)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(CELLS - 1)) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            unique case (item.kind)
              KIND_PLOT: st <= S_ROT;
              KIND_READ: st <= S_RD;
              default:   st <= S_EMIT;
            endcase
          end
        end
        S_ROT: begin
          if (stp == 3'd4 && rot == 2'd2) begin
            st <= pass ? S_SHM : S_PROJ;
          end
        end
        S_PROJ: st <= (wsum > 0) ? S_DX : S_EMIT;
        S_DX:   st <= (xnum > 0) ? S_DXW : S_EMIT;
        S_DXW: begin
          if (div_done) begin
            if (div_quo == '0 || div_quo >= NUM_W'(SCREEN_COLS)) begin
              st <= S_EMIT;
            end else begin
              st <= S_DY;
            end
          end
        end
        S_DY:   st <= (ynum > 0) ? S_DYW : S_EMIT;
        S_DYW: begin
          if (div_done) begin
            if (div_quo == '0 || div_quo >= NUM_W'(SCREEN_ROWS)) begin
              st <= S_EMIT;
            end else begin
              st <= S_DD;
            end
          end
        end
        S_DD:   st <= S_DDW;
        S_DDW: begin
          if (div_done) begin
            st <= S_ROT;
          end
        end
        S_SHM:  st <= S_SHA;
        S_SHA:  st <= S_CMP;
        S_CMP:  st <= S_EMIT;
        S_RD:   st <= S_EMIT;
        S_EMIT: begin
          if (res_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul;
    unique case (st)
      S_IDLE: begin
        rot      <= 2'd0;
        stp      <= 3'd0;
        pass     <= 1'b0;
        nux      <= item.ux;
        nuy      <= item.uy;
        vx       <= COORD_W'(item.ux) <<< 1;
        vy       <= COORD_W'(item.uy) <<< 1;
        vz       <= COORD_W'(item.ax) <<< 2;
        cell_idx <= item.addr[AW-1:0];
        res      <= '{written: 1'b0, cell_no: item.addr, glyph: GLYPH_SPACE};
      end
      S_ROT: begin
        unique case (stp)
          3'd1, 3'd3: acc <= ACC_W'(prod);
          3'd2:       pn  <= rq14(acc - ACC_W'(prod));
          default:    acc <= acc;
        endcase
        if (stp == 3'd4) begin
          stp <= 3'd0;
          rot <= (rot == 2'd2) ? 2'd0 : rot + 2'd1;
          unique case (rot)
            2'd0:    begin vy <= pn; vz <= qn; end
            2'd1:    begin vz <= pn; vx <= qn; end
            default: begin vx <= pn; vy <= qn; end
          endcase
        end else begin
          stp <= stp + 3'd1;
        end
        res <= '{written: 1'b0, cell_no: '0, glyph: GLYPH_SPACE};
      end
      S_PROJ: begin
        wreg <= DEN_W'(wsum);
        xnum <= (NUM_W+1)'(wsum) * K_COLS + (NUM_W+1)'(vx) * K_60;
        ynum <= (NUM_W+1)'(wsum) * K_ROWS + (NUM_W+1)'(vy) * K_30;
      end
      S_DXW: xp <= XP_W'(div_quo);
      S_DYW: yp <= YP_W'(div_quo);
      S_DDW: begin
        dq       <= (div_quo > NUM_W'(65535)) ? 16'hFFFF : div_quo[15:0];
        cell_idx <= AW'(yp) * AW'(SCREEN_COLS) + AW'(xp);
        vx       <= COORD_W'(nux);
        vy       <= COORD_W'(nuy);
        vz       <= '0;
        pass     <= 1'b1;
      end
      S_SHA: begin
        // floor by dropping 30 bits, then clamp to 0..11
        if (shv[ACC_W-1]) begin
          idx <= 4'd0;
        end else if (shv[ACC_W-1:30] > (ACC_W-30)'(11)) begin
          idx <= 4'd11;
        end else begin
          idx <= shv[33:30];
        end
      end
      S_CMP: begin
        if (dq > rd_data[15:0]) begin
          res <= '{written: 1'b1, cell_no: CELL_W'(cell_idx), glyph: glyph_of(idx)};
        end else begin
          res <= '{written: 1'b0, cell_no: CELL_W'(cell_idx), glyph: GLYPH_SPACE};
        end
      end
      S_RD: res.glyph <= glyph_of(rd_data[19:16]);
      default: res <= res;
    endcase
  end

endmodule

// File: rtl/prpzs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpzs_outq
// two-entry result queue facing the consumer
// ----------------------------------------------------------------------------
module prpzs_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  prpzs_pkg::result_t    res,
  input  logic                  res_valid,
  output logic                  res_ready,
  output prpzs_pkg::result_t    head,
  output logic                  empty,
  input  logic                  pop
);
  import prpzs_pkg::*;

  result_t    ent [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign res_ready = (cnt != 2'd2);
  assign empty     = (cnt == 2'd0);
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;
  assign head      = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wp] <= res;
    end
  end

endmodule
